>>> rtl/core/hpt_pkg.sv
// shared types and constants for the homogeneous point transform
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // command carried on s_tuser
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_POINT = 2'd1,
    CMD_DIR   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // status carried on m_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WZERO = 2'd1,
    ST_SAT   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/homogeneous_point_transform.sv
// 4x4 fixed-point vertex transform with perspective divide, fully pipelined
//
// Input beats arrive on s_tvalid/s_tready/s_tdata with the command on s_tuser.
// A write beat loads one column-major matrix entry and gives no output beat;
// a point beat is multiplied by the full matrix and divided by w; a direction
// beat uses the upper 3x3 part with no divide. Command 3 is dropped.
// Output beats carry x, y, z on m_tdata and the status on m_tuser.
// The pipe holds one multiply stage, one sum stage, one magnitude stage, one
// range-check stage, one restoring-divide stage per quotient bit, and the
// output register. It takes one beat per cycle while the output is not
// stalled; the divider is the deep part of the pipe.
// A write takes effect for the very next beat, also while earlier items are
// still in flight, since products are formed at the input edge.
// Reset loads the identity matrix and empties the pipe. When the receiver
// holds m_tready low with an output beat waiting, the whole pipe freezes and
// s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int SDW = ((4 + 4 * WORD_BITS + 7) / 8) * 8,
  localparam int MDW = ((3 * WORD_BITS + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  // entry_index, entry_value, point_x, point_y, point_z
  input  wire logic [SDW-1:0] s_tdata,
  // cmd
  input  wire logic [1:0]     s_tuser,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  // out_x, out_y, out_z
  output logic [MDW-1:0]      m_tdata,
  // status
  output logic [1:0]          m_tuser
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 3;
  localparam int NW = AW + F;
  localparam int CW = AW + F + W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic acc_in;
  assign acc_in = s_tvalid && en;

  // input field unpack
  logic [3:0]          in_idx;
  logic signed [W-1:0] in_val;
  logic signed [W-1:0] in_p [0:2];
  cmd_t                in_cmd;
  assign in_idx   = s_tdata[3:0];
  assign in_val   = s_tdata[4 +: W];
  assign in_p[0]  = s_tdata[4 + W +: W];
  assign in_p[1]  = s_tdata[4 + 2 * W +: W];
  assign in_p[2]  = s_tdata[4 + 3 * W +: W];
  assign in_cmd   = cmd_t'(s_tuser);

  // coefficient matrix, column-major
  logic signed [W-1:0] mat [0:15];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= ((i % 5) == 0) ? (W'(1) << F) : '0;
      end
    end else if (acc_in && in_cmd == CMD_WRITE) begin
      mat[in_idx] <= in_val;
    end
  end

  // stage 1: products
  logic                s1_v, s1_dir;
  logic signed [PW-1:0] s1_prod [0:3][0:2];
  logic signed [W-1:0]  s1_tr [0:3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= acc_in && (in_cmd == CMD_POINT || in_cmd == CMD_DIR);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dir <= (in_cmd == CMD_DIR);
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= PW'(mat[4 * c + r]) * PW'(in_p[c]);
        end
        s1_tr[r] <= (in_cmd == CMD_DIR) ? '0 : mat[12 + r];
      end
    end
  end

  // stage 2: exact row sums
  logic                s2_v, s2_dir;
  logic signed [AW-1:0] s2_acc [0:3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_dir <= s1_dir;
      for (int r = 0; r < 4; r++) begin
        s2_acc[r] <= AW'(s1_prod[r][0]) + AW'(s1_prod[r][1]) + AW'(s1_prod[r][2])
                   + (AW'(s1_tr[r]) <<< F);
      end
    end
  end

  // stage 3: sign and magnitude
  logic          s3_v, s3_dir, s3_wz;
  logic [AW-1:0] s3_mag [0:2];
  logic          s3_sgn [0:2];
  logic [AW-1:0] s3_wmag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_dir  <= s2_dir;
      s3_wmag <= s2_acc[3][AW-1] ? AW'(-s2_acc[3]) : AW'(s2_acc[3]);
      // a direction has no w, so it never reports a zero w
      s3_wz   <= !s2_dir && (s2_acc[3] == '0);
      for (int l = 0; l < 3; l++) begin
        s3_mag[l] <= s2_acc[l][AW-1] ? AW'(-s2_acc[l]) : AW'(s2_acc[l]);
        s3_sgn[l] <= s2_dir ? s2_acc[l][AW-1] : (s2_acc[l][AW-1] ^ s2_acc[3][AW-1]);
      end
    end
  end

  // divider pipe, index 0 is the range-check stage
  logic          dv   [0:W];
  logic          ddir [0:W];
  logic          dwz  [0:W];
  logic [AW-1:0] dden [0:W];
  logic [NW-1:0] drem [0:W][0:2];
  logic [W-1:0]  dq   [0:W][0:2];
  logic          dsgn [0:W][0:2];
  logic          dovf [0:W][0:2];

  // stage 4: numerator load and quotient range check
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= s3_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ddir[0] <= s3_dir;
      dwz[0]  <= s3_wz;
      dden[0] <= s3_wmag;
      for (int l = 0; l < 3; l++) begin
        drem[0][l] <= s3_dir ? NW'(s3_mag[l] >> F) : {s3_mag[l], {F{1'b0}}};
        dq[0][l]   <= '0;
        dsgn[0][l] <= s3_sgn[l];
        dovf[0][l] <= !s3_dir && !s3_wz &&
                      (CW'({s3_mag[l], {F{1'b0}}}) >= (CW'(s3_wmag) << W));
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int SH = W - 1 - k;
    logic          take [0:2];
    logic [CW-1:0] shd;
    assign shd = CW'(dden[k]) << SH;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign take[l] = !ddir[k] && !dwz[k] && !dovf[k][l] && (CW'(drem[k][l]) >= shd);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ddir[k+1] <= ddir[k];
        dwz[k+1]  <= dwz[k];
        dden[k+1] <= dden[k];
        for (int l = 0; l < 3; l++) begin
          drem[k+1][l] <= take[l] ? NW'(CW'(drem[k][l]) - shd) : drem[k][l];
          dq[k+1][l]   <= {dq[k][l][W-2:0], take[l]};
          dsgn[k+1][l] <= dsgn[k][l];
          dovf[k+1][l] <= dovf[k][l];
        end
      end
    end
  end

  // final clamp and status
  logic [NW-1:0] fmag [0:2];
  logic [W-1:0]  fval [0:2];
  logic          fsat [0:2];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fmag[l] = ddir[W] ? drem[W][l] : NW'(dq[W][l]);
      fsat[l] = 1'b0;
      if (dwz[W]) begin
        fval[l] = '0;
      end else if (dovf[W][l]) begin
        fsat[l] = 1'b1;
        fval[l] = dsgn[W][l] ? (W'(1) << (W - 1)) : ~(W'(1) << (W - 1));
      end else if (dsgn[W][l]) begin
        if (fmag[l] <= (NW'(1) << (W - 1))) begin
          fval[l] = W'(-fmag[l]);
        end else begin
          fsat[l] = 1'b1;
          fval[l] = W'(1) << (W - 1);
        end
      end else begin
        if (fmag[l] < (NW'(1) << (W - 1))) begin
          fval[l] = W'(fmag[l]);
        end else begin
          fsat[l] = 1'b1;
          fval[l] = ~(W'(1) << (W - 1));
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[W];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= MDW'({fval[2], fval[1], fval[0]});
      if (dwz[W]) begin
        m_tuser <= ST_WZERO;
      end else if (fsat[0] || fsat[1] || fsat[2]) begin
        m_tuser <= ST_SAT;
      end else begin
        m_tuser <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hpt_checker.sv
// port-level checks for the homogeneous point transform, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module hpt_checker
  import hpt_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int MDW = ((3 * WORD_BITS + 7) / 8) * 8
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           s_tready,
  input wire logic           m_tvalid,
  input wire logic           m_tready,
  input wire logic [MDW-1:0] m_tdata,
  input wire logic [1:0]     m_tuser
);

  // pipe is empty right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // input side stalls exactly when an output beat waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  // zero w gives zero coordinates
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_WZERO) |-> (m_tdata == '0))
    else $error("nonzero coordinates with zero w");

  // reserved status code never appears
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != ST_RSVD))
    else $error("reserved status on output");

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output beat changed under stall");

endmodule

bind homogeneous_point_transform hpt_checker #(.WORD_BITS(WORD_BITS)) u_hpt_checker (.*);
`default_nettype wire
